// ----- rtl/plc_pkg.sv -----
package plc_pkg;

   // list store geometry
   localparam int CAPACITY   = 128;
   localparam int GROUP      = 8;
   localparam int NUM_GROUPS = (CAPACITY + GROUP - 1) / GROUP;
   localparam int GIDX_W     = $clog2(GROUP);
   localparam int IDX_W      = $clog2(CAPACITY);
   localparam int CNT_W      = $clog2(CAPACITY + 1);

   // field widths
   localparam int DATA_W   = 32;
   localparam int POS_W    = 8;
   localparam int OP_W     = 2;
   localparam int STS_W    = 2;
   localparam int LIMIT_W  = 8;
   localparam int CMP_W    = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

   localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(128);

   // opcodes
   localparam logic [OP_W-1:0] OP_GET    = 2'd0;
   localparam logic [OP_W-1:0] OP_LOCATE = 2'd1;
   localparam logic [OP_W-1:0] OP_INSERT = 2'd2;
   localparam logic [OP_W-1:0] OP_DELETE = 2'd3;

   // status codes
   localparam logic [STS_W-1:0] STS_OK        = 2'd0;
   localparam logic [STS_W-1:0] STS_OVERFLOW  = 2'd1;
   localparam logic [STS_W-1:0] STS_BAD_POS   = 2'd2;
   localparam logic [STS_W-1:0] STS_UNDERFLOW = 2'd3;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CELL,
      ST_MERGE
   } plc_state_type;

   // command broadcast along the cell row
   typedef struct packed {
      logic              shift_up;
      logic              shift_down;
      logic [CMP_W-1:0]  position;
      logic [DATA_W-1:0] value;
      logic [CMP_W-1:0]  count;
   } plc_cmd_type;

   // one group's registered summary
   typedef struct packed {
      logic              any_hit;
      logic [GIDX_W-1:0] first_hit;
      logic [DATA_W-1:0] pick;
   } plc_grp_type;

endpackage

// ----- rtl/plc_cell.sv -----
module plc_cell (
   input  logic                        clock,
   input  plc_pkg::plc_cmd_type        cmd,
   input  logic [plc_pkg::IDX_W-1:0]   cell_index,
   input  logic [plc_pkg::DATA_W-1:0]  left_data,
   input  logic [plc_pkg::DATA_W-1:0]  right_data,
   output logic [plc_pkg::DATA_W-1:0]  data,
   output logic                        hit,
   output logic                        sel
);
   import plc_pkg::*;

   logic [DATA_W-1:0] data_ff;
   logic [DATA_W-1:0] data_in;
   logic [CMP_W-1:0]  slot;
   logic              at_or_after;

   // 1-based position of this cell
   assign slot        = CMP_W'(cell_index) + CMP_W'(1);
   assign at_or_after = (slot >= cmd.position);

   // shift in from a neighbour, or take the new word
   always_comb begin
      data_in = data_ff;
      if (cmd.shift_up && at_or_after) begin
         data_in = (slot == cmd.position) ? cmd.value : left_data;
      end else if (cmd.shift_down && at_or_after) begin
         data_in = right_data;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   // match and select flags for the reduction
   assign data = data_ff;
   assign hit  = (data_ff == cmd.value) && (slot <= cmd.count);
   assign sel  = (slot == cmd.position);

endmodule

// ----- rtl/plc_group.sv -----
module plc_group (
   input  logic                                             clock,
   input  logic [plc_pkg::GROUP-1:0][plc_pkg::DATA_W-1:0]   cell_data,
   input  logic [plc_pkg::GROUP-1:0]                        cell_hit,
   input  logic [plc_pkg::GROUP-1:0]                        cell_sel,
   output plc_pkg::plc_grp_type                             summary
);
   import plc_pkg::*;

   plc_grp_type grp_ff;
   plc_grp_type grp_in;

   // first match wins, selected word is or-ed out
   always_comb begin
      grp_in = '0;
      for (int i = GROUP - 1; i >= 0; i--) begin
         if (cell_hit[i]) begin
            grp_in.any_hit   = 1'b1;
            grp_in.first_hit = GIDX_W'(i);
         end
         if (cell_sel[i]) begin
            grp_in.pick = grp_in.pick | cell_data[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      grp_ff <= grp_in;
   end

   assign summary = grp_ff;

endmodule

// ----- rtl/positional_list_table_core.sv -----
// Positional list table: an ordered list of signed 32-bit words held in a row
// of storage cells, addressed by 1-based position. A request (get, locate,
// insert, delete) is taken when start is high and busy is low; busy then stays
// high, blocking new requests, through ST_CELL, which shifts the cell row and
// registers per-group match and select summaries, and ST_MERGE, which merges
// the groups into the result beat registers behind the rsp_ ports, marked by
// rsp_strobe. The result beat is shown for exactly one cycle and cannot be
// held off, so it must be taken when rsp_strobe is high. capacity_limit is
// written through csr_wr_en/csr_wr_data and resets to 128; the user must write
// it only while no request is in flight, which the block does not enforce.
// After reset the list is empty and ready at once: no clearing pass is needed.
module positional_list_table_core (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   output logic                               busy,
   input  logic [plc_pkg::OP_W-1:0]           req_opcode,
   input  logic [plc_pkg::POS_W-1:0]          req_position,
   input  logic signed [plc_pkg::DATA_W-1:0]  req_value,
   input  logic                               csr_wr_en,
   input  logic [plc_pkg::LIMIT_W-1:0]        csr_wr_data,
   output logic                               rsp_strobe,
   output logic signed [plc_pkg::DATA_W-1:0]  rsp_read_value,
   output logic [plc_pkg::POS_W-1:0]          rsp_found_position,
   output logic [plc_pkg::STS_W-1:0]          rsp_status,
   output logic [plc_pkg::POS_W-1:0]          rsp_entry_count,
   output logic                               rsp_is_empty
);
   import plc_pkg::*;

   localparam int ROW = NUM_GROUPS * GROUP;

   plc_state_type state_ff, state_in;

   logic [LIMIT_W-1:0] limit_ff;
   logic [CNT_W-1:0]   count_ff, count_in;

   logic [OP_W-1:0]    op_ff;
   logic [CMP_W-1:0]   pos_ff;
   logic [DATA_W-1:0]  val_ff;
   logic [STS_W-1:0]   status_ff, status_in;
   logic               ok_ff;

   logic               accept;
   logic               cell_step;

   logic [CMP_W-1:0]   pos_z;
   logic [CMP_W-1:0]   cnt_z;

   plc_cmd_type        cmd;

   logic [ROW-1:0][DATA_W-1:0] cell_data;
   logic [ROW-1:0]             cell_hit;
   logic [ROW-1:0]             cell_sel;
   plc_grp_type                grp_sum [NUM_GROUPS];

   logic               any_hit;
   logic [CMP_W-1:0]   found;
   logic [DATA_W-1:0]  pick;

   logic               rsp_strobe_ff;
   logic [DATA_W-1:0]  rsp_read_ff, rsp_read_in;
   logic [POS_W-1:0]   rsp_found_ff, rsp_found_in;
   logic [STS_W-1:0]   rsp_status_ff;
   logic [POS_W-1:0]   rsp_count_ff;
   logic               rsp_empty_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:  if (start) state_in = ST_CELL;
         ST_CELL:  state_in = ST_MERGE;
         ST_MERGE: state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   // state outputs
   always_comb begin
      busy      = 1'b1;
      cell_step = 1'b0;
      case (state_ff)
         ST_IDLE:  busy = 1'b0;
         ST_CELL:  cell_step = 1'b1;
         ST_MERGE: busy = 1'b1;
         default:  busy = 1'b1;
      endcase
   end

   assign accept = start && !busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // capacity limit register
   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= LIMIT_RESET;
      end else if (csr_wr_en) begin
         limit_ff <= csr_wr_data;
      end
   end

   // request checks against the current length
   assign pos_z = CMP_W'(req_position);
   assign cnt_z = CMP_W'(count_ff);

   always_comb begin
      status_in = STS_OK;
      case (req_opcode)
         OP_GET: begin
            if (pos_z == '0 || pos_z > cnt_z) status_in = STS_BAD_POS;
         end
         OP_LOCATE: status_in = STS_OK;
         OP_INSERT: begin
            if (cnt_z >= CMP_W'(limit_ff) || cnt_z >= CMP_W'(CAPACITY)) begin
               status_in = STS_OVERFLOW;
            end else if (pos_z == '0 || pos_z > cnt_z + CMP_W'(1)) begin
               status_in = STS_BAD_POS;
            end
         end
         OP_DELETE: begin
            if (cnt_z == '0) begin
               status_in = STS_UNDERFLOW;
            end else if (pos_z == '0 || pos_z > cnt_z) begin
               status_in = STS_BAD_POS;
            end
         end
         default: status_in = STS_OK;
      endcase
   end

   // request beat capture
   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff     <= req_opcode;
         pos_ff    <= pos_z;
         val_ff    <= req_value;
         status_ff <= status_in;
         ok_ff     <= (status_in == STS_OK);
      end
   end

   // command along the row
   always_comb begin
      cmd.shift_up   = cell_step && ok_ff && (op_ff == OP_INSERT);
      cmd.shift_down = cell_step && ok_ff && (op_ff == OP_DELETE);
      cmd.position   = pos_ff;
      cmd.value      = val_ff;
      cmd.count      = CMP_W'(count_ff);
   end

   // list length
   always_comb begin
      count_in = count_ff;
      if (cmd.shift_up) begin
         count_in = count_ff + CNT_W'(1);
      end else if (cmd.shift_down) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   // cell row, padded to whole groups
   for (genvar i = 0; i < ROW; i++) begin : g_cell
      if (i < CAPACITY) begin : g_real
         logic [DATA_W-1:0] left_w;
         logic [DATA_W-1:0] right_w;

         if (i == 0) begin : g_first
            assign left_w = '0;
         end else begin : g_mid_l
            assign left_w = cell_data[i-1];
         end

         if (i == CAPACITY - 1) begin : g_last
            assign right_w = '0;
         end else begin : g_mid_r
            assign right_w = cell_data[i+1];
         end

         plc_cell u_cell (
            .clock      (clock),
            .cmd        (cmd),
            .cell_index (IDX_W'(i)),
            .left_data  (left_w),
            .right_data (right_w),
            .data       (cell_data[i]),
            .hit        (cell_hit[i]),
            .sel        (cell_sel[i])
         );
      end else begin : g_pad
         assign cell_data[i] = '0;
         assign cell_hit[i]  = 1'b0;
         assign cell_sel[i]  = 1'b0;
      end
   end

   // group summaries, registered
   for (genvar g = 0; g < NUM_GROUPS; g++) begin : g_group
      plc_group u_group (
         .clock     (clock),
         .cell_data (cell_data[g*GROUP +: GROUP]),
         .cell_hit  (cell_hit[g*GROUP +: GROUP]),
         .cell_sel  (cell_sel[g*GROUP +: GROUP]),
         .summary   (grp_sum[g])
      );
   end

   // merge the groups: lowest matching group wins
   always_comb begin
      any_hit = 1'b0;
      found   = '0;
      pick    = '0;
      for (int g = NUM_GROUPS - 1; g >= 0; g--) begin
         if (grp_sum[g].any_hit) begin
            any_hit = 1'b1;
            found   = CMP_W'(g * GROUP) + CMP_W'(grp_sum[g].first_hit) + CMP_W'(1);
         end
         pick = pick | grp_sum[g].pick;
      end
   end

   always_comb begin
      rsp_read_in  = '0;
      rsp_found_in = '0;
      if (ok_ff && (op_ff == OP_GET || op_ff == OP_DELETE)) begin
         rsp_read_in = pick;
      end
      if (op_ff == OP_LOCATE && any_hit) begin
         rsp_found_in = POS_W'(found);
      end
   end

   // result beat register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= (state_ff == ST_MERGE);
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_MERGE) begin
         rsp_read_ff   <= rsp_read_in;
         rsp_found_ff  <= rsp_found_in;
         rsp_status_ff <= status_ff;
         rsp_count_ff  <= POS_W'(count_ff);
         rsp_empty_ff  <= (count_ff == '0);
      end
   end

   assign rsp_strobe         = rsp_strobe_ff;
   assign rsp_read_value     = rsp_read_ff;
   assign rsp_found_position = rsp_found_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_entry_count    = rsp_count_ff;
   assign rsp_is_empty       = rsp_empty_ff;

`ifndef NO_ASSERTIONS
   // length never exceeds the store
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(CAPACITY))
      else $error("list length beyond capacity");

   // length only moves in the cell cycle
   a_count_hold: assert property (@(posedge clock) disable iff (reset)
      state_ff != ST_CELL |=> $stable(count_ff))
      else $error("list length changed outside the cell cycle");

   // a result beat follows only a merge cycle
   a_strobe_src: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(state_ff == ST_MERGE))
      else $error("result beat without a merge");

   // empty flag agrees with the length
   a_empty_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_is_empty == (rsp_entry_count == '0)))
      else $error("empty flag disagrees with length");

   // a found position comes with ok status and no read word
   a_found_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_found_position != '0 |->
         rsp_status == STS_OK && rsp_read_value == '0)
      else $error("found position on a non-locate result");
`endif

endmodule

// ----- tb/positional_list_checker.sv -----
module positional_list_checker
   import plc_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic                      busy,
   input  logic [OP_W-1:0]           req_opcode,
   input  logic [POS_W-1:0]          req_position,
   input  logic signed [DATA_W-1:0]  req_value,
   input  logic                      csr_wr_en,
   input  logic [LIMIT_W-1:0]        csr_wr_data,
   input  logic                      rsp_strobe,
   input  logic signed [DATA_W-1:0]  rsp_read_value,
   input  logic [POS_W-1:0]          rsp_found_position,
   input  logic [STS_W-1:0]          rsp_status,
   input  logic [POS_W-1:0]          rsp_entry_count,
   input  logic                      rsp_is_empty,
   output int                        mismatch_count,
   output int                        outstanding,
   output int                        results_checked
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic signed [DATA_W-1:0] read_value;
      logic [POS_W-1:0]         found_position;
      logic [STS_W-1:0]         status;
      logic [POS_W-1:0]         entry_count;
      logic                     is_empty;
   } list_result_t;

   // shadow of the list contents, its length and the capacity register
   logic signed [DATA_W-1:0] cells [CAPACITY];
   int                       list_len;
   logic [LIMIT_W-1:0]       cap_limit;
   list_result_t             awaited_q[$];

   initial begin
      mismatch_count  = 0;
      outstanding     = 0;
      results_checked = 0;
   end

   // work out one request's response and apply it to the shadow list
   task automatic apply_list_op(input logic [OP_W-1:0] op, input logic [POS_W-1:0] pos,
                                input logic signed [DATA_W-1:0] val,
                                output list_result_t res);
      int p;
      int lim;
      int j;
      p   = pos;
      lim = (cap_limit < CAPACITY) ? int'(cap_limit) : CAPACITY;
      res = '0;
      case (op)
         OP_GET: begin
            if (p >= 1 && p <= list_len)
               res.read_value = cells[p-1];
            else
               res.status = STS_BAD_POS;
         end
         OP_LOCATE: begin
            // first match wins, all 32 bits compared
            for (j = 0; j < list_len; j++)
               if (res.found_position == 0 && cells[j] == val)
                  res.found_position = POS_W'(j + 1);
         end
         OP_INSERT: begin
            // overflow takes priority over a bad position
            if (list_len >= lim)
               res.status = STS_OVERFLOW;
            else if (p < 1 || p > list_len + 1)
               res.status = STS_BAD_POS;
            else begin
               for (j = list_len; j >= p; j--)
                  cells[j] = cells[j-1];
               cells[p-1] = val;
               list_len++;
            end
         end
         default: begin
            // underflow on an empty list takes priority over a bad position
            if (list_len == 0)
               res.status = STS_UNDERFLOW;
            else if (p < 1 || p > list_len)
               res.status = STS_BAD_POS;
            else begin
               res.read_value = cells[p-1];
               for (j = p; j < list_len; j++)
                  cells[j-1] = cells[j];
               list_len--;
            end
         end
      endcase
      res.entry_count = POS_W'(list_len);
      res.is_empty    = (list_len == 0);
   endtask

   task automatic compare_field(input string field, input logic signed [63:0] want,
                                input logic signed [63:0] got);
      if (want !== got) begin
         $error("%s: expected %0d, got %0d", field, want, got);
         mismatch_count++;
      end
   endtask

   // watch both channels and the register port at every edge
   always @(posedge clock) begin : watch
      list_result_t want;
      if (reset) begin
         list_len  = 0;
         cap_limit = LIMIT_RESET;
         awaited_q.delete();
      end else begin
         // result beat against the oldest expectation
         if (rsp_strobe) begin
            if (awaited_q.size() == 0) begin
               $error("result beat with no request waiting for it");
               mismatch_count++;
            end else begin
               want = awaited_q.pop_front();
               compare_field("read_value", want.read_value, rsp_read_value);
               compare_field("found_position", want.found_position, rsp_found_position);
               compare_field("status", want.status, rsp_status);
               compare_field("entry_count", want.entry_count, rsp_entry_count);
               compare_field("is_empty", want.is_empty, rsp_is_empty);
               results_checked++;
            end
         end
         if (csr_wr_en)
            cap_limit = csr_wr_data;
         // request beat taken
         if (start && !busy) begin
            apply_list_op(req_opcode, req_position, req_value, want);
            awaited_q.push_back(want);
         end
      end
      outstanding = awaited_q.size();
   end

endmodule

// ----- tb/tb_positional_list_table_core.sv -----
module tb_positional_list_table_core;
   timeunit 1ns;
   timeprecision 1ps;
   import plc_pkg::*;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      start = 1'b0;
   logic                      busy;
   logic [OP_W-1:0]           req_opcode = '0;
   logic [POS_W-1:0]          req_position = '0;
   logic signed [DATA_W-1:0]  req_value = '0;
   logic                      csr_wr_en = 1'b0;
   logic [LIMIT_W-1:0]        csr_wr_data = '0;
   logic                      rsp_strobe;
   logic signed [DATA_W-1:0]  rsp_read_value;
   logic [POS_W-1:0]          rsp_found_position;
   logic [STS_W-1:0]          rsp_status;
   logic [POS_W-1:0]          rsp_entry_count;
   logic                      rsp_is_empty;
   int                        mismatch_count;
   int                        outstanding;
   int                        results_checked;

   // stimulus-side bookkeeping: rough occupancy so positions land in range
   int          occupancy = 0;
   int          limit_now = 128;
   int          idle_pct  = 34;
   int          limit_writes = 0;
   int          op_tally [4] = '{0, 0, 0, 0};
   logic [31:0] value_pool [16];

   always #1 clock = ~clock;

   positional_list_table_core dut (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_opcode         (req_opcode),
      .req_position       (req_position),
      .req_value          (req_value),
      .csr_wr_en          (csr_wr_en),
      .csr_wr_data        (csr_wr_data),
      .rsp_strobe         (rsp_strobe),
      .rsp_read_value     (rsp_read_value),
      .rsp_found_position (rsp_found_position),
      .rsp_status         (rsp_status),
      .rsp_entry_count    (rsp_entry_count),
      .rsp_is_empty       (rsp_is_empty)
   );

   positional_list_checker list_monitor (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_opcode         (req_opcode),
      .req_position       (req_position),
      .req_value          (req_value),
      .csr_wr_en          (csr_wr_en),
      .csr_wr_data        (csr_wr_data),
      .rsp_strobe         (rsp_strobe),
      .rsp_read_value     (rsp_read_value),
      .rsp_found_position (rsp_found_position),
      .rsp_status         (rsp_status),
      .rsp_entry_count    (rsp_entry_count),
      .rsp_is_empty       (rsp_is_empty),
      .mismatch_count     (mismatch_count),
      .outstanding        (outstanding),
      .results_checked    (results_checked)
   );

   // present one request beat, with random idle cycles ahead of it
   task automatic send_request(input logic [OP_W-1:0] op, input logic [POS_W-1:0] pos,
                               input logic [DATA_W-1:0] val);
      int lim;
      while ($urandom_range(0, 99) < idle_pct) begin
         start        <= 1'b0;
         req_opcode   <= OP_W'($urandom);
         req_position <= POS_W'($urandom);
         req_value    <= $urandom;
         @(posedge clock);
      end
      start        <= 1'b1;
      req_opcode   <= op;
      req_position <= pos;
      req_value    <= val;
      do @(posedge clock); while (busy);
      op_tally[op]++;
      // keep the occupancy estimate in step
      lim = (limit_now < CAPACITY) ? limit_now : CAPACITY;
      if (op == OP_INSERT && occupancy < lim && pos >= 1 && pos <= occupancy + 1)
         occupancy++;
      else if (op == OP_DELETE && occupancy > 0 && pos >= 1 && pos <= occupancy)
         occupancy--;
   endtask

   // wait for the block to drain, then write the capacity register
   task automatic write_limit(input int lim);
      start <= 1'b0;
      do @(negedge clock); while (outstanding != 0 || busy);
      @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= LIMIT_W'(lim);
      @(posedge clock);
      csr_wr_en <= 1'b0;
      limit_now = lim;
      limit_writes++;
   endtask

   // mostly well-formed requests against the current occupancy, some noise
   task automatic random_request(input int ins_pct, input int del_pct);
      logic [OP_W-1:0]   op;
      logic [POS_W-1:0]  pos;
      logic [DATA_W-1:0] val;
      int                roll;
      if ($urandom_range(0, 99) < 15) begin
         op  = OP_W'($urandom);
         pos = POS_W'($urandom);
         val = $urandom;
      end else begin
         roll = $urandom_range(0, 99);
         if (roll < ins_pct)
            op = OP_INSERT;
         else if (roll < ins_pct + del_pct)
            op = OP_DELETE;
         else if (roll[0])
            op = OP_GET;
         else
            op = OP_LOCATE;
         if (occupancy == 0 && (op == OP_GET || op == OP_DELETE))
            op = OP_INSERT;
         // values mostly from a small pool so locate hits and duplicates happen
         val = ($urandom_range(0, 99) < 70) ? value_pool[$urandom_range(0, 15)] : $urandom;
         case (op)
            OP_INSERT: begin
               case ($urandom_range(0, 3))
                  0:       pos = 1;
                  1:       pos = POS_W'(occupancy + 1);
                  default: pos = POS_W'($urandom_range(1, occupancy + 1));
               endcase
               if ($urandom_range(0, 4) == 0)
                  value_pool[$urandom_range(0, 15)] = val;
            end
            OP_LOCATE: pos = POS_W'($urandom);
            default:   pos = POS_W'($urandom_range(1, occupancy));
         endcase
      end
      send_request(op, pos, val);
   endtask

   task automatic run_phase(input int lim, input int items, input int ins_pct,
                            input int del_pct, input int idle);
      write_limit(lim);
      idle_pct = idle;
      repeat (items) random_request(ins_pct, del_pct);
   endtask

   initial begin
      value_pool = '{32'h0, 32'h1, 32'hffff_ffff, 32'h7fff_ffff, 32'h8000_0000,
                     32'h5555_5555, 32'haaaa_aaaa, $urandom, $urandom, $urandom,
                     $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: empty list cases
      send_request(OP_GET, 1, 0);
      send_request(OP_DELETE, 1, 0);
      send_request(OP_LOCATE, 0, 0);
      send_request(OP_INSERT, 0, 5);
      send_request(OP_INSERT, 2, 5);
      // directed: build a short list at front, end and middle, value extremes
      send_request(OP_INSERT, 1, 32'h7fff_ffff);
      send_request(OP_INSERT, 1, 32'h8000_0000);
      send_request(OP_INSERT, 3, 32'hffff_ffff);
      send_request(OP_INSERT, 2, 32'h0);
      send_request(OP_INSERT, 255, 32'h1);
      send_request(OP_INSERT, 1, 32'hffff_ffff);
      // directed: reads in and out of range
      send_request(OP_GET, 0, 0);
      send_request(OP_GET, 1, 0);
      send_request(OP_GET, 5, 0);
      send_request(OP_GET, 6, 0);
      send_request(OP_GET, 255, 0);
      // directed: locate with duplicates, extremes and a miss
      send_request(OP_LOCATE, 0, 32'hffff_ffff);
      send_request(OP_LOCATE, 0, 32'h8000_0000);
      send_request(OP_LOCATE, 255, 32'h7fff_ffff);
      send_request(OP_LOCATE, 0, 32'h7fff_fffe);
      // directed: deletes out of range, middle, end and front
      send_request(OP_DELETE, 0, 0);
      send_request(OP_DELETE, 255, 0);
      send_request(OP_DELETE, 6, 0);
      send_request(OP_DELETE, 3, 0);
      send_request(OP_DELETE, 4, 0);
      send_request(OP_DELETE, 1, 0);

      // random phases over a range of capacity settings
      run_phase(1, 50, 40, 30, 34);
      run_phase(0, 30, 40, 20, 34);
      run_phase(128, 200, 80, 5, 34);
      run_phase(100, 90, 20, 70, 34);
      run_phase(255, 120, 35, 55, 0);
      run_phase(2, 80, 25, 70, 34);
      run_phase(128, 80, 45, 40, 34);

      // drain, with a bound
      start <= 1'b0;
      for (int n = 0; n < 2000 && outstanding != 0; n++)
         @(negedge clock);
      repeat (8) @(posedge clock);
      if (outstanding != 0)
         $error("%0d responses never arrived", outstanding);

      $display("run covered %0d get, %0d locate, %0d insert, %0d delete requests",
               op_tally[OP_GET], op_tally[OP_LOCATE], op_tally[OP_INSERT],
               op_tally[OP_DELETE]);
      $display("%0d responses compared across %0d capacity settings",
               results_checked, limit_writes + 1);
      if (mismatch_count == 0 && outstanding == 0)
         $display("** positional_list_table_core: PASSED **");
      else
         $display("** positional_list_table_core: FAILED **");
      $finish;
   end

   // watchdog
   initial begin
      #400us;
      $display("** positional_list_table_core: FAILED **");
      $finish;
   end

endmodule

// ----- files.f -----
rtl/plc_pkg.sv
rtl/plc_cell.sv
rtl/plc_group.sv
rtl/positional_list_table_core.sv
tb/positional_list_checker.sv
tb/tb_positional_list_table_core.sv
